// ===== rtl/sato_pkg.sv =====
// Shared types and constants for the load-segment address translator.
// Holds the in/out word structs, the table entry type and the code constants.
// No dependencies.
package sato_pkg;

  localparam int MaxSegments = 16;
  localparam int SegIdxW     = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int SegCountW   = 5;
  localparam int CntW        = ($clog2(MaxSegments + 1) > SegCountW) ?
                               $clog2(MaxSegments + 1) : SegCountW;
  localparam int AddrW       = 64;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 64;

  // Request codes
  localparam logic ReqWrite     = 1'b0;
  localparam logic ReqTranslate = 1'b1;

  // Result status codes
  localparam logic [1:0] StTranslated = 2'd0;
  localparam logic [1:0] StNotFound   = 2'd1;
  localparam logic [1:0] StWritten    = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSegCount   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPageOffset = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [3:0]       entry_index;
    logic [AddrW-1:0] seg_base;
    logic [AddrW-1:0] seg_length;
    logic [AddrW-1:0] seg_file_pos;
    logic [AddrW-1:0] lookup_addr;
    logic [AddrW-1:0] phys_addr;
    logic             phys_given;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] file_pos;
    logic             used_fallback;
  } out_t;

  // One stored segment; wraps is set when base + length carries out of 64 bits
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] length;
    logic [AddrW-1:0] file_pos;
    logic             wraps;
  } seg_entry_t;

  // Result of one range check by the shared compare unit
  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] diff;
  } match_t;

endpackage

// ===== rtl/segment_address_to_offset.sv =====
// Top level of the load-segment address translator: sequencer, config
// registers and output register. Depends on sato_pkg, sato_seg_ram, sato_range_unit.
//
//   port group   direction  handshake               payload
//   in_*         in         in_valid_i / in_stall_o  sato_pkg::in_t
//   out_*        out        out_valid_o / out_stall_i sato_pkg::out_t
//   cfg_*        in         cfg_we_i                cfg_index_i, cfg_data_i
//
// A translate word scans the table at one entry per cycle through the single read
// port of the table and one range unit, over N = min(segment_count, 16) entries,
// and scans again with the fallback address if the first pass finds no hit.
// One word is in flight at a time; in_stall_o is high until its result is
// loaded into the output register, which holds it while out_stall_i is high.
// Reset clears the config registers and control state; the table has no reset.
module segment_address_to_offset (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sato_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sato_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [sato_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sato_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sato_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e             state_q;
  in_t                req_q;
  logic [SegCountW-1:0] seg_count_q;
  logic [AddrW-1:0]   page_offset_q;
  logic [AddrW-1:0]   addr_q;
  logic [CntW-1:0]    issue_q;
  logic               eval_vld_q;
  logic               pass_q;
  logic [1:0]         res_status_q;
  logic               res_fallback_q;
  logic [AddrW-1:0]   diff_q;
  logic [AddrW-1:0]   fpos_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [CntW-1:0]    scan_n;
  logic               in_accept;
  logic               load_out;
  logic               rd_en;
  logic               wr_en;
  logic [AddrW:0]     end_sum;
  seg_entry_t         wr_entry;
  seg_entry_t         rd_entry;
  match_t             match;
  logic               hit;
  logic               pass_end;

  // Saturate the active entry count at the table depth
  assign scan_n = (CntW'(seg_count_q) > CntW'(MaxSegments)) ?
                  CntW'(MaxSegments) : CntW'(seg_count_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  assign end_sum        = {1'b0, req_q.seg_base} + {1'b0, req_q.seg_length};
  assign wr_entry.base     = req_q.seg_base;
  assign wr_entry.length   = req_q.seg_length;
  assign wr_entry.file_pos = req_q.seg_file_pos;
  assign wr_entry.wraps    = end_sum[AddrW];
  assign wr_en = (state_q == ST_WRITE) && (32'(req_q.entry_index) < MaxSegments);

  assign rd_en = (state_q == ST_SCAN) && (issue_q < scan_n);

  sato_seg_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (SegIdxW'(req_q.entry_index)),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (issue_q[SegIdxW-1:0]),
    .rdata_o (rd_entry)
  );

  sato_range_unit u_range (
    .addr_i  (addr_q),
    .entry_i (rd_entry),
    .match_o (match)
  );

  assign hit      = eval_vld_q && match.hit;
  assign pass_end = !hit && (issue_q == scan_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q   <= '0;
      page_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSegCount:   seg_count_q   <= cfg_data_i[SegCountW-1:0];
        CfgPageOffset: page_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      req_q          <= '0;
      addr_q         <= '0;
      issue_q        <= '0;
      eval_vld_q     <= 1'b0;
      pass_q         <= 1'b0;
      res_status_q   <= '0;
      res_fallback_q <= 1'b0;
      diff_q         <= '0;
      fpos_q         <= '0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            req_q      <= in_data_i;
            addr_q     <= in_data_i.lookup_addr;
            issue_q    <= '0;
            eval_vld_q <= 1'b0;
            pass_q     <= 1'b0;
            state_q    <= (in_data_i.req_type == ReqWrite) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_WRITE: begin
          res_status_q   <= StWritten;
          res_fallback_q <= 1'b0;
          state_q        <= ST_RESP;
        end
        ST_SCAN: begin
          if (hit) begin
            res_status_q   <= StTranslated;
            res_fallback_q <= pass_q;
            diff_q         <= match.diff;
            fpos_q         <= rd_entry.file_pos;
            state_q        <= ST_RESP;
          end else if (pass_end) begin
            if (!pass_q) begin
              // restart the scan with the fallback address
              addr_q     <= req_q.phys_given ? (req_q.phys_addr + page_offset_q) :
                                               req_q.lookup_addr;
              pass_q     <= 1'b1;
              issue_q    <= '0;
              eval_vld_q <= 1'b0;
            end else begin
              res_status_q   <= StNotFound;
              res_fallback_q <= 1'b0;
              state_q        <= ST_RESP;
            end
          end else begin
            eval_vld_q <= rd_en;
            if (rd_en) begin
              issue_q <= issue_q + 1'b1;
            end
          end
        end
        ST_RESP: begin
          if (load_out) begin
            out_q.status        <= res_status_q;
            out_q.file_pos      <= (res_status_q == StTranslated) ? (diff_q + fpos_q) : '0;
            out_q.used_fallback <= res_fallback_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/sato_seg_ram.sv =====
// Segment table storage: one write port, one read port with registered data.
// Depends on sato_pkg.
module sato_seg_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [sato_pkg::SegIdxW-1:0] waddr_i,
  input  sato_pkg::seg_entry_t         wdata_i,
  input  logic                         re_i,
  input  logic [sato_pkg::SegIdxW-1:0] raddr_i,
  output sato_pkg::seg_entry_t         rdata_o
);
  import sato_pkg::*;

  seg_entry_t mem [MaxSegments];
  seg_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sato_range_unit.sv =====
// Shared range check: does addr fall inside one segment, and how far in.
// Depends on sato_pkg.
module sato_range_unit (
  input  logic [sato_pkg::AddrW-1:0] addr_i,
  input  sato_pkg::seg_entry_t       entry_i,
  output sato_pkg::match_t           match_o
);
  import sato_pkg::*;

  logic [AddrW:0] sub;

  // borrow out of addr - base means addr is below base
  assign sub = {1'b0, addr_i} - {1'b0, entry_i.base};

  // With addr >= base, addr < base + length is diff < length unless the end wraps
  assign match_o.hit  = !sub[AddrW] && !entry_i.wraps && (sub[AddrW-1:0] < entry_i.length);
  assign match_o.diff = sub[AddrW-1:0];

endmodule
